### rtl/core/csxps_pkg.sv
// Shared types and constants for the cell-seeded xorshift Poisson sampler.
// Used by the top level and by the iterative divider; no dependencies.
`default_nettype none

package csxps_pkg;

   // Item opcodes.
   localparam logic [1:0] OP_SEED    = 2'd0;
   localparam logic [1:0] OP_RAW     = 2'd1;
   localparam logic [1:0] OP_POISSON = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_SEED_OFFSET    = 2'd0;
   localparam logic [1:0] CSR_LAMBDA_Q16     = 2'd1;
   localparam logic [1:0] CSR_EXP_NEG_LAMBDA = 2'd2;
   localparam logic [1:0] CSR_COUNT_LIMIT    = 2'd3;

   localparam logic [31:0] RST_SEED_OFFSET    = 32'd0;
   localparam logic [31:0] RST_LAMBDA_Q16     = 32'd65536;
   localparam logic [31:0] RST_EXP_NEG_LAMBDA = 32'd1580030168;
   localparam logic [15:0] RST_COUNT_LIMIT    = 16'd10000;

   // Integer hash constants for seeding from a cell.
   localparam logic [31:0] HASH_XOR = 32'd61;
   localparam logic [31:0] HASH_MUL = 32'd668265261;

   // Term times lambda, shifted right by 16, leaves a 48-bit dividend.
   localparam int QUO_WIDTH = 48;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [31:0] xs_next(input logic [31:0] s);
      logic [31:0] a;
      logic [31:0] b;
      a = s ^ (s << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

   // First half of the cell hash, up to the big multiply.
   function automatic logic [31:0] hash_pre(input logic [31:0] s);
      logic [31:0] v1;
      logic [31:0] v2;
      v1 = (s ^ HASH_XOR) ^ (s >> 16);
      v2 = (v1 << 3) + v1;
      return v2 ^ (v2 >> 4);
   endfunction

endpackage

`default_nettype wire

### rtl/core/csxps_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on csxps_pkg for the status struct.
`default_nettype none

module csxps_div import csxps_pkg::*; #(
   parameter int DIVIDEND_WIDTH = 48,
   parameter int DIVISOR_WIDTH  = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [DIVIDEND_WIDTH-1:0] dividend,
   input  wire logic [DIVISOR_WIDTH-1:0]  divisor,
   output logic [DIVIDEND_WIDTH-1:0]      quotient,
   output div_stat_type                   stat
);

   localparam int STEP_WIDTH = $clog2(DIVIDEND_WIDTH);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [STEP_WIDTH-1:0]     step_ff, step_in;
   logic [DIVIDEND_WIDTH-1:0] quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_WIDTH:0]    trial;
   logic                      fits;

   // The remainder shifted left with the next dividend bit brought in.
   assign trial = {rem_ff, quo_ff[DIVIDEND_WIDTH-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVIDEND_WIDTH-2:0], fits};
         rem_in  = fits ? DIVISOR_WIDTH'(trial - {1'b0, dvs_ff})
                        : trial[DIVISOR_WIDTH-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_WIDTH'(DIVIDEND_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

### rtl/core/cell_seeded_xorshift_poisson_sampler.sv
// Cell-seeded xorshift32 generator with an inverse-transform Poisson sampler.
// Depends on csxps_pkg and on the iterative divider csxps_div.
//
// Usage: an item transfers on the req_ channel when req_valid and req_ready are
// both high. The opcode picks a seed from the cell coordinates, a raw draw or a
// Poisson draw. Each item gives exactly one result on the rsp_ channel.
// The block works on one item at a time and drops req_ready until its result
// sits in the output register; it then takes the next item even while that
// result still waits for rsp_ready.
// The unused opcode returns the generator state. A seed passes through the
// mix, multiply and finish states; a Poisson draw loops through test,
// multiply, start and divide once per counted event. Each Poisson pass
// costs one shared 32x32 multiply (registered) and a 48-step restoring
// divide, one quotient bit per cycle; the divide sets the pass length.
// A stalled receiver holds the result in the output register; a finished
// item waits in ST_OUT for that register to free before the next is taken.
// Reset clears the generator state to zero and loads the register defaults.
// Configuration writes on the csr_ port are registered; lambda is read on
// every Poisson pass, while e^-lambda and the count limit are copied when a draw starts.
`default_nettype none

module cell_seeded_xorshift_poisson_sampler import csxps_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [15:0] req_cell_x,
   input  wire logic [15:0] req_cell_y,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_result_value,
   output logic             rsp_limit_hit,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_SEED_MIX  = 4'd1;
   localparam logic [3:0] ST_SEED_MUL  = 4'd2;
   localparam logic [3:0] ST_SEED_FIN  = 4'd3;
   localparam logic [3:0] ST_POIS_TEST = 4'd4;
   localparam logic [3:0] ST_POIS_MUL  = 4'd5;
   localparam logic [3:0] ST_POIS_GO   = 4'd6;
   localparam logic [3:0] ST_POIS_DIV  = 4'd7;
   localparam logic [3:0] ST_OUT       = 4'd8;

   localparam logic [32:0] CNT_MASK = (33'd1 << COUNT_WIDTH) - 33'd1;

   logic [3:0]  state_ff, state_in;
   logic [31:0] seed_offset_ff, lambda_ff, exp_neg_ff;
   logic [15:0] count_limit_ff;
   logic [31:0] prng_ff, prng_in;

   logic [15:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [31:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [63:0] prod_ff;
   logic [31:0] u_ff, u_in, term_ff, term_in, total_ff, total_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in, limit_ff, limit_in;
   logic [31:0] res_ff, res_in;
   logic        flag_ff, flag_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff;
   logic        rsp_flag_ff;

   logic                 div_start;
   logic [QUO_WIDTH-1:0] div_quo;
   div_stat_type         div_stat;

   logic        in_xfer;
   logic        out_load;
   logic [31:0] xs_val;
   logic [31:0] seed_sum;
   logic [31:0] seed_val;
   logic [31:0] hash_val;
   logic [31:0] term_sat;
   logic [32:0] total_sum;
   logic [32:0] limit_wide;

   assign in_xfer  = req_valid && req_ready;
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign xs_val   = xs_next(prng_ff);
   assign seed_sum = {cy_ff, cx_ff} + seed_offset_ff;
   assign seed_val = (seed_sum == 32'd0) ? 32'd1 : seed_sum;
   assign hash_val = prod_ff[31:0] ^ (prod_ff[31:0] >> 15);
   assign term_sat = (div_quo[QUO_WIDTH-1:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
   assign total_sum = {1'b0, total_ff} + {1'b0, term_sat};
   assign limit_wide = ({17'd0, count_limit_ff} < CNT_MASK) ? {17'd0, count_limit_ff}
                                                            : CNT_MASK;
   assign div_start = (state_ff == ST_POIS_GO);

   csxps_div #(
      .DIVIDEND_WIDTH (QUO_WIDTH),
      .DIVISOR_WIDTH  (COUNT_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff[QUO_WIDTH+15:16]),
      .divisor  (cnt_ff),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   always_comb begin
      state_in = state_ff;
      prng_in  = prng_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      u_in     = u_ff;
      term_in  = term_ff;
      total_in = total_ff;
      cnt_in   = cnt_ff;
      limit_in = limit_ff;
      res_in   = res_ff;
      flag_in  = flag_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_xfer) begin
               flag_in = 1'b0;
               unique case (req_opcode)
                  OP_SEED: begin
                     cx_in    = req_cell_x;
                     cy_in    = req_cell_y;
                     state_in = ST_SEED_MIX;
                  end
                  OP_RAW: begin
                     prng_in  = xs_val;
                     res_in   = xs_val;
                     state_in = ST_OUT;
                  end
                  OP_POISSON: begin
                     prng_in  = xs_val;
                     u_in     = xs_val;
                     term_in  = exp_neg_ff;
                     total_in = exp_neg_ff;
                     cnt_in   = '0;
                     limit_in = COUNT_WIDTH'(limit_wide);
                     state_in = ST_POIS_TEST;
                  end
                  OP_UNUSED: begin
                     res_in   = prng_ff;
                     state_in = ST_OUT;
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_SEED_MIX: begin
            mul_a_in = hash_pre(seed_val);
            mul_b_in = HASH_MUL;
            state_in = ST_SEED_MUL;
         end
         ST_SEED_MUL: state_in = ST_SEED_FIN;
         ST_SEED_FIN: begin
            prng_in  = hash_val;
            res_in   = hash_val;
            state_in = ST_OUT;
         end
         ST_POIS_TEST: begin
            if ((u_ff > total_ff) && (cnt_ff < limit_ff)) begin
               cnt_in   = cnt_ff + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
               mul_a_in = term_ff;
               mul_b_in = lambda_ff;
               state_in = ST_POIS_MUL;
            end else begin
               res_in   = 32'(cnt_ff);
               flag_in  = (u_ff > total_ff);
               state_in = ST_OUT;
            end
         end
         ST_POIS_MUL: state_in = ST_POIS_GO;
         ST_POIS_GO:  state_in = ST_POIS_DIV;
         ST_POIS_DIV: begin
            if (div_stat.done) begin
               term_in  = term_sat;
               total_in = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
               state_in = ST_POIS_TEST;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         prng_ff        <= 32'd0;
         rsp_valid_ff   <= 1'b0;
         seed_offset_ff <= RST_SEED_OFFSET;
         lambda_ff      <= RST_LAMBDA_Q16;
         exp_neg_ff     <= RST_EXP_NEG_LAMBDA;
         count_limit_ff <= RST_COUNT_LIMIT;
      end else begin
         state_ff     <= state_in;
         prng_ff      <= prng_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SEED_OFFSET:    seed_offset_ff <= csr_wdata;
               CSR_LAMBDA_Q16:     lambda_ff      <= csr_wdata;
               CSR_EXP_NEG_LAMBDA: exp_neg_ff     <= csr_wdata;
               CSR_COUNT_LIMIT:    count_limit_ff <= csr_wdata[15:0];
               default:            seed_offset_ff <= seed_offset_ff;
            endcase
         end
      end
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      // The shared multiplier; its product is always registered before use.
      prod_ff  <= 64'(mul_a_ff) * 64'(mul_b_ff);
      u_ff     <= u_in;
      term_ff  <= term_in;
      total_ff <= total_in;
      cnt_ff   <= cnt_in;
      limit_ff <= limit_in;
      res_ff   <= res_in;
      flag_ff  <= flag_in;
      if (out_load) begin
         rsp_value_ff <= res_ff;
         rsp_flag_ff  <= flag_ff;
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_limit_hit    = rsp_flag_ff;

   // The divider only runs while the sequencer waits for it.
   a_div_busy_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == ST_POIS_DIV))
      else $error("divider busy outside the divide wait");

   // The divide wait never stalls on an idle divider.
   a_div_wait_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POIS_DIV) |-> (div_stat.busy || div_stat.done))
      else $error("waiting on a divider that is not running");

   // The count never passes the effective limit.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POIS_TEST) |-> (cnt_ff <= limit_ff))
      else $error("Poisson count beyond its limit");

   // A new result is loaded only into a free or draining output register.
   a_out_slot: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote a pending transfer");

endmodule

`default_nettype wire
